>>> sv/button_status_led_controller_top_macros.svh
// assertion macros for the button and status led controller
// used by the top level only; no other dependencies
`ifndef BUTTON_STATUS_LED_CONTROLLER_TOP_MACROS_SVH
`define BUTTON_STATUS_LED_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bslc assertion failed");

// next-cycle implication, disabled during reset
`define BSLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bslc assertion failed");

`endif

>>> sv/bslc_pkg.sv
// shared types and constants for the button and status led controller
// no dependencies
`default_nettype none

package bslc_pkg;

  localparam int PCT_W      = 7;
  localparam int LED_W      = 8;
  localparam int MS_W       = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_PRESS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BATT_SHOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_HALF  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_PCT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MID_PCT     = 3'd5;

  // register reset values
  localparam logic [MS_W-1:0]  LONG_PRESS_RST  = 16'd5000;
  localparam logic [MS_W-1:0]  SHORT_PRESS_RST = 16'd1500;
  localparam logic [MS_W-1:0]  BATT_SHOW_RST   = 16'd2000;
  localparam logic [MS_W-1:0]  BLINK_HALF_RST  = 16'd500;
  localparam logic [PCT_W-1:0] LOW_PCT_RST     = 7'd20;
  localparam logic [PCT_W-1:0] MID_PCT_RST     = 7'd60;

  // led intensities
  localparam logic [LED_W-1:0] LED_FULL  = 8'd255;
  localparam logic [LED_W-1:0] LED_AMBER = 8'd100;
  localparam logic [LED_W-1:0] LED_OFF   = 8'd0;

  typedef enum logic [1:0] {
    COLOUR_RED   = 2'd0,
    COLOUR_AMBER = 2'd1,
    COLOUR_GREEN = 2'd2
  } colour_t;

  typedef struct packed {
    logic [MS_W-1:0]  long_press_ms;
    logic [MS_W-1:0]  short_press_ms;
    logic [MS_W-1:0]  battery_show_ms;
    logic [MS_W-1:0]  blink_half_ms;
    logic [PCT_W-1:0] low_battery_pct;
    logic [PCT_W-1:0] mid_battery_pct;
  } cfg_t;

  typedef struct packed {
    logic             button_down;
    logic [PCT_W-1:0] battery_pct;
    logic             portal_active;
    logic             link_up;
    logic             radio_off;
  } item_t;

  typedef struct packed {
    logic [LED_W-1:0] red;
    logic [LED_W-1:0] green;
    logic [LED_W-1:0] blue;
    logic             refresh;
    logic             reset_request;
  } result_t;

  typedef struct packed {
    logic reset_latched;
    logic showing_battery;
  } status_t;

endpackage

`default_nettype wire

>>> sv/bslc_if.sv
// valid/ready channel interfaces for tick items and pixel results
// depends on bslc_pkg
`default_nettype none

interface bslc_tick_if;
  import bslc_pkg::*;
  logic             valid;
  logic             ready;
  logic             button_down;
  logic [PCT_W-1:0] battery_pct;
  logic             portal_active;
  logic             link_up;
  logic             radio_off;

  modport source (output valid, button_down, battery_pct, portal_active, link_up,
                  radio_off, input ready);
  modport sink (input valid, button_down, battery_pct, portal_active, link_up,
                radio_off, output ready);
endinterface

interface bslc_pixel_if;
  import bslc_pkg::*;
  logic             valid;
  logic             ready;
  logic [LED_W-1:0] red;
  logic [LED_W-1:0] green;
  logic [LED_W-1:0] blue;
  logic             refresh;
  logic             reset_request;

  modport source (output valid, red, green, blue, refresh, reset_request, input ready);
  modport sink (input valid, red, green, blue, refresh, reset_request, output ready);
endinterface

`default_nettype wire

>>> sv/bslc_cfg.sv
// apb-style configuration register file
// depends on bslc_pkg
`default_nettype none

module bslc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bslc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bslc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [bslc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output bslc_pkg::cfg_t                        cfg
);
  import bslc_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms   <= LONG_PRESS_RST;
      cfg.short_press_ms  <= SHORT_PRESS_RST;
      cfg.battery_show_ms <= BATT_SHOW_RST;
      cfg.blink_half_ms   <= BLINK_HALF_RST;
      cfg.low_battery_pct <= LOW_PCT_RST;
      cfg.mid_battery_pct <= MID_PCT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LONG_PRESS:  cfg.long_press_ms   <= pwdata[MS_W-1:0];
        REG_SHORT_PRESS: cfg.short_press_ms  <= pwdata[MS_W-1:0];
        REG_BATT_SHOW:   cfg.battery_show_ms <= pwdata[MS_W-1:0];
        REG_BLINK_HALF:  cfg.blink_half_ms   <= pwdata[MS_W-1:0];
        REG_LOW_PCT:     cfg.low_battery_pct <= pwdata[PCT_W-1:0];
        REG_MID_PCT:     cfg.mid_battery_pct <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LONG_PRESS:  prdata = CFG_DATA_W'(cfg.long_press_ms);
      REG_SHORT_PRESS: prdata = CFG_DATA_W'(cfg.short_press_ms);
      REG_BATT_SHOW:   prdata = CFG_DATA_W'(cfg.battery_show_ms);
      REG_BLINK_HALF:  prdata = CFG_DATA_W'(cfg.blink_half_ms);
      REG_LOW_PCT:     prdata = CFG_DATA_W'(cfg.low_battery_pct);
      REG_MID_PCT:     prdata = CFG_DATA_W'(cfg.mid_battery_pct);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bslc_core.sv
// per-tick button and pixel state machine: state registers and next-state logic
// depends on bslc_pkg
`default_nettype none

module bslc_core #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  bslc_pkg::item_t        item,
  input  bslc_pkg::cfg_t         cfg,
  output bslc_pkg::result_t      res,
  output bslc_pkg::status_t      status
);
  import bslc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic                  button_held, button_held_next;
  logic [TIMER_BITS-1:0] hold_count, hold_count_next;
  logic                  reset_latched, reset_latched_next;
  logic                  showing_battery, showing_battery_next;
  logic [TIMER_BITS-1:0] battery_count, battery_count_next;
  colour_t               battery_colour, battery_colour_next;
  logic [TIMER_BITS-1:0] blink_count, blink_count_next;
  logic                  blink_on, blink_on_next;
  logic                  last_show, last_show_next;

  logic                  need;
  logic [TIMER_BITS-1:0] hc, bc, kc;

  function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] c);
    return (c == TMAX) ? TMAX : c + TIMER_BITS'(1);
  endfunction

  always_comb begin
    button_held_next     = button_held;
    reset_latched_next   = reset_latched;
    showing_battery_next = showing_battery;
    battery_colour_next  = battery_colour;
    blink_on_next        = blink_on;
    hc                   = hold_count;
    bc                   = battery_count;
    kc                   = blink_count;
    need                 = 1'b0;
    res                  = '0;

    // button
    if (item.button_down) begin
      if (!button_held) begin
        button_held_next   = 1'b1;
        hc                 = '0;
        reset_latched_next = 1'b0;
      end
      if ((CMP_W'(hc) > CMP_W'(cfg.long_press_ms)) && !reset_latched_next) begin
        reset_latched_next = 1'b1;
        res.reset_request  = 1'b1;
      end
    end else begin
      if (button_held && (CMP_W'(hold_count) < CMP_W'(cfg.short_press_ms))
          && !reset_latched) begin
        if (item.battery_pct <= cfg.low_battery_pct) begin
          battery_colour_next = COLOUR_RED;
        end else if (item.battery_pct <= cfg.mid_battery_pct) begin
          battery_colour_next = COLOUR_AMBER;
        end else begin
          battery_colour_next = COLOUR_GREEN;
        end
        showing_battery_next = 1'b1;
        bc                   = '0;
      end
      button_held_next = 1'b0;
    end

    // pixel
    if (showing_battery_next) begin
      if (CMP_W'(bc) < CMP_W'(cfg.battery_show_ms)) begin
        case (battery_colour_next)
          COLOUR_RED:   res.red = LED_FULL;
          COLOUR_AMBER: begin
            res.red   = LED_FULL;
            res.green = LED_AMBER;
          end
          default:      res.green = LED_FULL;
        endcase
      end else begin
        showing_battery_next = 1'b0;
      end
      need = 1'b1;
    end else if (item.portal_active || (!item.link_up && !item.radio_off)) begin
      if (CMP_W'(kc) >= CMP_W'(cfg.blink_half_ms)) begin
        kc            = '0;
        blink_on_next = !blink_on;
      end
      if (blink_on_next) begin
        if (item.portal_active) begin
          res.blue = LED_FULL;
        end else begin
          res.red = LED_FULL;
        end
      end
      need = 1'b1;
    end

    // when no refresh, last_show was already clear and need is clear
    res.refresh    = need || last_show;
    last_show_next = need;

    hold_count_next    = tick_up(hc);
    battery_count_next = tick_up(bc);
    blink_count_next   = tick_up(kc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held     <= 1'b0;
      hold_count      <= '0;
      reset_latched   <= 1'b0;
      showing_battery <= 1'b0;
      battery_count   <= '0;
      battery_colour  <= COLOUR_RED;
      blink_count     <= '0;
      blink_on        <= 1'b0;
      last_show       <= 1'b1;
    end else if (adv) begin
      button_held     <= button_held_next;
      hold_count      <= hold_count_next;
      reset_latched   <= reset_latched_next;
      showing_battery <= showing_battery_next;
      battery_count   <= battery_count_next;
      battery_colour  <= battery_colour_next;
      blink_count     <= blink_count_next;
      blink_on        <= blink_on_next;
      last_show       <= last_show_next;
    end
  end

  assign status.reset_latched   = reset_latched;
  assign status.showing_battery = showing_battery;

endmodule

`default_nettype wire

>>> sv/button_status_led_controller_top.sv
// an accepted tick is held in the input register, its result then in the result register
// throughput: one tick per cycle unless the result stalls, set by the single state-update stage in bslc_core
// the input ready only drops when the input register is full and the result is stalled
// reset: synchronous, active high; clears pipeline valids and the button/pixel state,
// config registers return to their default values
// depends on bslc_pkg, bslc_if, bslc_cfg, bslc_core and the assertion macro header
`default_nettype none

`include "button_status_led_controller_top_macros.svh"

module button_status_led_controller_top #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  bslc_tick_if.sink                             tick,
  bslc_pixel_if.source                          pixel,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bslc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bslc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [bslc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import bslc_pkg::*;

  cfg_t    cfg;
  status_t core_status;
  result_t step_res;

  // input register
  logic    s1_valid;
  item_t   s1_item;

  // result register
  logic    out_valid;
  result_t out_res;

  logic    stall;
  logic    adv;

  // result held with no taker stops the state update
  assign stall      = out_valid && !pixel.ready;
  assign adv        = s1_valid && !stall;
  assign tick.ready = !s1_valid || !stall;

  bslc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bslc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (s1_item),
    .cfg    (cfg),
    .res    (step_res),
    .status (core_status)
  );

  // input register: loads whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready) begin
      s1_item.button_down   <= tick.button_down;
      s1_item.battery_pct   <= tick.battery_pct;
      s1_item.portal_active <= tick.portal_active;
      s1_item.link_up       <= tick.link_up;
      s1_item.radio_off     <= tick.radio_off;
    end
  end

  // result register: new result on each state update, cleared once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign pixel.valid         = out_valid;
  assign pixel.red           = out_res.red;
  assign pixel.green         = out_res.green;
  assign pixel.blue          = out_res.blue;
  assign pixel.refresh       = out_res.refresh;
  assign pixel.reset_request = out_res.reset_request;

  // a reset request always leaves the reset latch set
  `BSLC_ASSERT_NEXT(a_req_sets_latch, clk, rst, adv && step_res.reset_request, core_status.reset_latched)
  // state only moves when a tick is processed
  `BSLC_ASSERT_NEXT(a_state_holds, clk, rst, !adv, $stable(core_status))
  // no refresh means a dark pixel
  `BSLC_ASSERT_NOW(a_dark_without_refresh, clk, rst, adv && !step_res.refresh, step_res.red == LED_OFF && step_res.green == LED_OFF && step_res.blue == LED_OFF)
  // input backpressure only when both stages are full
  `BSLC_ASSERT_NOW(a_ready_low_full, clk, rst, !tick.ready, s1_valid && out_valid && !pixel.ready)

endmodule

`default_nettype wire

>>> tb/sv/button_status_led_controller_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for button_status_led_controller_top: tick and pixel transfers,
// register writes with readback, an in-bench pixel predictor and a result scoreboard
// depends on bslc_pkg, bslc_if and the rtl of the block

module button_status_led_controller_top_test;
  import bslc_pkg::*;

  localparam int TIMER_BITS      = 16;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int PRESSURE_AT     = 300;     // results seen before the long result stall
  localparam int PRESSURE_CYCLES = 200;
  localparam int MAX_HOLD_TICKS  = 40;      // one press held under the largest thresholds
  localparam int MAX_REPORTS     = 10;

  // pixel values that can be read off directly
  localparam result_t PX_IDLE  = {LED_OFF, LED_OFF, LED_OFF, 1'b0, 1'b0};
  localparam result_t PX_BLACK = {LED_OFF, LED_OFF, LED_OFF, 1'b1, 1'b0};
  localparam result_t PX_RED   = {LED_FULL, LED_OFF, LED_OFF, 1'b1, 1'b0};
  localparam result_t PX_AMBER = {LED_FULL, LED_AMBER, LED_OFF, 1'b1, 1'b0};
  localparam result_t PX_GREEN = {LED_OFF, LED_FULL, LED_OFF, 1'b1, 1'b0};

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    item_t                 tick;
    bit                    typed;   // want holds a hand-written pixel
    result_t               want;
    logic [REG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bslc_tick_if  tick_ch ();
  bslc_pixel_if pixel_ch ();

  button_status_led_controller_top #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .pixel  (pixel_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the controller and its registers
  // ---------------------------------------------------------------------------
  cfg_t                  live_cfg = {LONG_PRESS_RST, SHORT_PRESS_RST, BATT_SHOW_RST,
                                     BLINK_HALF_RST, LOW_PCT_RST, MID_PCT_RST};
  logic                  pressed_q   = 1'b0;
  logic [TIMER_BITS-1:0] press_ticks = '0;
  logic                  reset_sent  = 1'b0;
  logic                  batt_lit    = 1'b0;
  logic [TIMER_BITS-1:0] batt_ticks  = '0;
  colour_t               batt_colour = COLOUR_RED;
  logic [TIMER_BITS-1:0] blink_ticks = '0;
  logic                  blink_phase = 1'b0;
  logic                  lit_last    = 1'b1;   // pixel is pushed once right after reset

  result_t   pixel_expect[$];   // predicted pixels, oldest first
  stim_row_t stim_table[$];

  // run bookkeeping
  int  fail_count    = 0;
  int  results_seen  = 0;
  int  ticks_sent    = 0;
  int  reg_writes    = 0;
  int  request_count = 0;
  int  show_count    = 0;
  int  cycle_count   = 0;
  bit  slow_ok       = 1'b1;   // long gaps allowed on both sides
  bit  tx_calm       = 1'b0;   // sender offers back to back
  bit  rx_calm       = 1'b0;   // receiver starts no new random stalls

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] c);
    return (c == '1) ? c : c + TIMER_BITS'(1);
  endfunction

  // one millisecond tick: button first, then the status pixel, then the timers
  function automatic result_t next_pixel(input item_t t);
    result_t px;
    logic    lit_now;
    px      = PX_IDLE;
    lit_now = 1'b0;
    if (t.button_down) begin
      if (!pressed_q) begin
        pressed_q   = 1'b1;
        press_ticks = '0;
        reset_sent  = 1'b0;
      end
      if (press_ticks > live_cfg.long_press_ms && !reset_sent) begin
        reset_sent       = 1'b1;
        px.reset_request = 1'b1;
        request_count++;
      end
    end else begin
      // quick release latches a battery colour, red checked before amber
      if (pressed_q && press_ticks < live_cfg.short_press_ms && !reset_sent) begin
        if (t.battery_pct <= live_cfg.low_battery_pct) batt_colour = COLOUR_RED;
        else if (t.battery_pct <= live_cfg.mid_battery_pct) batt_colour = COLOUR_AMBER;
        else batt_colour = COLOUR_GREEN;
        batt_lit   = 1'b1;
        batt_ticks = '0;
        show_count++;
      end
      pressed_q = 1'b0;
    end

    if (batt_lit) begin
      if (batt_ticks < live_cfg.battery_show_ms) begin
        case (batt_colour)
          COLOUR_RED: begin
            px.red = LED_FULL;
          end
          COLOUR_AMBER: begin
            px.red   = LED_FULL;
            px.green = LED_AMBER;
          end
          default: begin
            px.green = LED_FULL;
          end
        endcase
      end else begin
        batt_lit = 1'b0;   // expiry tick shows black but still pushes
      end
      lit_now = 1'b1;
    end else if (t.portal_active || (!t.link_up && !t.radio_off)) begin
      if (blink_ticks >= live_cfg.blink_half_ms) begin
        blink_ticks = '0;
        blink_phase = !blink_phase;
      end
      if (blink_phase) begin
        if (t.portal_active) px.blue = LED_FULL;
        else px.red = LED_FULL;
      end
      lit_now = 1'b1;
    end

    if (lit_now || lit_last) begin
      px.refresh = 1'b1;
      lit_last   = lit_now;
    end

    press_ticks = sat_inc(press_ticks);
    batt_ticks  = sat_inc(batt_ticks);
    blink_ticks = sat_inc(blink_ticks);
    return px;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: mismatch on %s, expected %0d got %0d", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // random shaping
  // ---------------------------------------------------------------------------
  function automatic int pick_stall();
    if (!slow_ok) return 1;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int tx_gap();
    if (tx_calm || $urandom_range(0, 9) < 6) return 0;
    return pick_stall();
  endfunction

  // battery levels cluster on the colour thresholds and the range ends
  function automatic logic [PCT_W-1:0] pick_pct();
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 100;
      2:       v = live_cfg.low_battery_pct;
      3:       v = live_cfg.low_battery_pct + 1;
      4:       v = live_cfg.mid_battery_pct + $urandom_range(0, 1);
      default: v = $urandom_range(0, 100);
    endcase
    return (v > 100) ? 7'd100 : v[PCT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // tick source: drive at the falling edge, transfer seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_tick(input item_t t, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = tx_gap();
    if (gap > 0) begin
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid         = 1'b1;
    tick_ch.button_down   = t.button_down;
    tick_ch.battery_pct   = t.battery_pct;
    tick_ch.portal_active = t.portal_active;
    tick_ch.link_up       = t.link_up;
    tick_ch.radio_off     = t.radio_off;
    forever begin
      @(posedge clk);
      if (tick_ch.ready) break;
    end
    // the predictor steps on every accepted tick, typed rows included
    predicted = next_pixel(t);
    pixel_expect.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  // stop offering ticks and let every predicted pixel come out
  task automatic drain_results();
    tick_ch.valid = 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // register write then readback, only once the block is idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    case (idx)
      REG_LONG_PRESS:  live_cfg.long_press_ms   = value[MS_W-1:0];
      REG_SHORT_PRESS: live_cfg.short_press_ms  = value[MS_W-1:0];
      REG_BATT_SHOW:   live_cfg.battery_show_ms = value[MS_W-1:0];
      REG_BLINK_HALF:  live_cfg.blink_half_ms   = value[MS_W-1:0];
      REG_LOW_PCT:     live_cfg.low_battery_pct = value[PCT_W-1:0];
      REG_MID_PCT:     live_cfg.mid_battery_pct = value[PCT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (prdata !== value) flag_mismatch("register readback", value, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_LONG_PRESS, c.long_press_ms);
    write_reg(REG_SHORT_PRESS, c.short_press_ms);
    write_reg(REG_BATT_SHOW, c.battery_show_ms);
    write_reg(REG_BLINK_HALF, c.blink_half_ms);
    write_reg(REG_LOW_PCT, c.low_battery_pct);
    write_reg(REG_MID_PCT, c.mid_battery_pct);
  endtask

  task automatic add_tick(input item_t t, input bit typed, input result_t want);
    stim_row_t row;
    row.kind  = ROW_TICK;
    row.tick  = t;
    row.typed = typed;
    row.want  = want;
    row.idx   = '0;
    row.value = '0;
    stim_table.push_back(row);
  endtask

  task automatic add_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.tick  = '0;
    row.typed = 1'b0;
    row.want  = PX_IDLE;
    row.idx   = idx;
    row.value = value;
    stim_table.push_back(row);
  endtask

  // mostly well-formed presses (hold, release, rest) around the thresholds,
  // with a share of fully random noise sequences
  task automatic run_random(input int n_items);
    int    sent;
    int    dur;
    int    rest;
    int    k;
    int    shortest;
    int    longest;
    bit    noisy;
    item_t t;
    sent = 0;
    while (sent < n_items) begin
      noisy           = ($urandom_range(0, 9) == 0);
      tx_calm         = ($urandom_range(0, 3) == 0);
      t.portal_active = ($urandom_range(0, 3) == 0);
      t.link_up       = 1'($urandom_range(0, 1));
      t.radio_off     = ($urandom_range(0, 3) == 0);
      shortest = (live_cfg.short_press_ms > 60) ? 60 : live_cfg.short_press_ms;
      longest  = (live_cfg.long_press_ms > 55) ? 55 : live_cfg.long_press_ms;
      case ($urandom_range(0, 2))
        0:       dur = $urandom_range(1, shortest);
        1:       dur = $urandom_range((longest > 1) ? longest - 1 : 1, longest + 3);
        default: dur = $urandom_range(1, longest + 5);
      endcase
      rest = live_cfg.battery_show_ms + 2 * live_cfg.blink_half_ms + 4;
      rest = $urandom_range(1, (rest > 60) ? 60 : rest);
      for (k = 0; k < dur + rest; k++) begin
        t.button_down = noisy ? 1'($urandom_range(0, 1)) : (k < dur);
        t.battery_pct = pick_pct();
        if (noisy || $urandom_range(0, 15) == 0) begin
          t.portal_active = 1'($urandom_range(0, 1));
          t.link_up       = 1'($urandom_range(0, 1));
          t.radio_off     = 1'($urandom_range(0, 1));
        end
        send_tick(t, 1'b0, PX_IDLE);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pixel sink: random stalls, calm stretches and one long hold-off so the
  // block fills up and drops its tick ready
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int stall_left;
    bit pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        pixel_ch.ready = 1'b0;
        stall_left--;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done  = 1'b1;
        pixel_ch.ready = 1'b0;
        stall_left     = PRESSURE_CYCLES - 1;
      end else if (rx_calm || $urandom_range(0, 9) < 6) begin
        pixel_ch.ready = 1'b1;
      end else begin
        pixel_ch.ready = 1'b0;
        stall_left     = pick_stall() - 1;
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: each pixel transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_check
    result_t want;
    result_t got;
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      results_seen++;
      got = {pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.refresh,
             pixel_ch.reset_request};
      if (pixel_expect.size() == 0) begin
        flag_mismatch("pixel transfer with nothing predicted", 0, got);
      end else begin
        want = pixel_expect.pop_front();
        if (got.red !== want.red) flag_mismatch("red", want.red, got.red);
        if (got.green !== want.green) flag_mismatch("green", want.green, got.green);
        if (got.blue !== want.blue) flag_mismatch("blue", want.blue, got.blue);
        if (got.refresh !== want.refresh) flag_mismatch("refresh", want.refresh, got.refresh);
        if (got.reset_request !== want.reset_request)
          flag_mismatch("reset_request", want.reset_request, got.reset_request);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d pixels still predicted", cycle_count,
             pixel_expect.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t  c;
    item_t t;
    tick_ch.valid         = 1'b0;
    tick_ch.button_down   = 1'b0;
    tick_ch.battery_pct   = '0;
    tick_ch.portal_active = 1'b0;
    tick_ch.link_up       = 1'b1;
    tick_ch.radio_off     = 1'b0;
    pixel_ch.ready        = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    rst                   = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset register values
    // fields: button_down, battery_pct, portal_active, link_up, radio_off
    add_tick({1'b0, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b1, PX_BLACK);    // push left over from reset
    add_tick({1'b0, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b1, PX_IDLE);
    add_tick({1'b1, 7'd100, 1'b0, 1'b1, 1'b0}, 1'b1, PX_IDLE);
    add_tick({1'b0, 7'd100, 1'b0, 1'b1, 1'b0}, 1'b1, PX_GREEN);  // full charge is green
    add_tick({1'b1, 7'd0, 1'b1, 1'b1, 1'b0}, 1'b1, PX_GREEN);    // battery beats portal
    add_tick({1'b0, 7'd0, 1'b1, 1'b1, 1'b0}, 1'b1, PX_RED);
    add_tick({1'b1, 7'd20, 1'b0, 1'b1, 1'b0}, 1'b1, PX_RED);
    add_tick({1'b0, 7'd20, 1'b0, 1'b1, 1'b0}, 1'b1, PX_RED);     // on the low level
    add_tick({1'b1, 7'd21, 1'b0, 1'b0, 1'b1}, 1'b1, PX_RED);
    add_tick({1'b0, 7'd21, 1'b0, 1'b0, 1'b1}, 1'b1, PX_AMBER);
    add_tick({1'b1, 7'd61, 1'b0, 1'b1, 1'b0}, 1'b1, PX_AMBER);
    add_tick({1'b0, 7'd61, 1'b0, 1'b1, 1'b0}, 1'b1, PX_GREEN);   // above the mid level
    // tiny timers, low level above mid level
    add_reg(REG_LONG_PRESS, 32'd2);
    add_reg(REG_SHORT_PRESS, 32'd2);
    add_reg(REG_BATT_SHOW, 32'd2);
    add_reg(REG_BLINK_HALF, 32'd1);
    add_reg(REG_LOW_PCT, 32'd100);
    add_reg(REG_MID_PCT, 32'd0);
    add_tick({1'b0, 7'd50, 1'b0, 1'b1, 1'b0}, 1'b1, PX_GREEN);
    add_tick({1'b0, 7'd50, 1'b0, 1'b1, 1'b0}, 1'b1, PX_BLACK);   // battery show expires
    add_tick({1'b0, 7'd50, 1'b0, 1'b1, 1'b0}, 1'b1, PX_BLACK);   // trailing push
    add_tick({1'b0, 7'd50, 1'b1, 1'b1, 1'b0}, 1'b0, PX_IDLE);    // portal blink
    add_tick({1'b0, 7'd50, 1'b1, 1'b1, 1'b0}, 1'b0, PX_IDLE);
    add_tick({1'b0, 7'd50, 1'b0, 1'b0, 1'b0}, 1'b0, PX_IDLE);    // link down blink
    add_tick({1'b0, 7'd50, 1'b0, 1'b0, 1'b1}, 1'b0, PX_IDLE);    // radio off, nothing lit
    add_tick({1'b1, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b0, PX_IDLE);     // long press
    add_tick({1'b1, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b0, PX_IDLE);
    add_tick({1'b1, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b0, PX_IDLE);
    add_tick({1'b1, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b0, PX_IDLE);     // reset request
    add_tick({1'b0, 7'd0, 1'b0, 1'b1, 1'b0}, 1'b0, PX_IDLE);     // latch blocks the colour
    add_tick({1'b1, 7'd100, 1'b0, 1'b1, 1'b1}, 1'b0, PX_IDLE);   // new press clears the latch
    add_tick({1'b0, 7'd100, 1'b0, 1'b1, 1'b1}, 1'b0, PX_IDLE);   // red wins over amber
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REG) write_reg(stim_table[i].idx, stim_table[i].value);
      else send_tick(stim_table[i].tick, stim_table[i].typed, stim_table[i].want);
    end

    // random part over several settings, extremes among them
    set_config({16'd12, 16'd5, 16'd7, 16'd3, 7'd20, 7'd60});
    run_random(350);
    set_config({16'd1, 16'hFFFF, 16'd1, 16'd1, 7'd100, 7'd0});
    run_random(120);
    set_config({16'd3, 16'd2, 16'd4, 16'd2, 7'd0, 7'd100});
    run_random(150);
    for (int p = 0; p < 2; p++) begin
      c.long_press_ms   = MS_W'($urandom_range(1, 40));
      c.short_press_ms  = MS_W'($urandom_range(1, 20));
      c.battery_show_ms = MS_W'($urandom_range(1, 20));
      c.blink_half_ms   = MS_W'($urandom_range(1, 10));
      c.low_battery_pct = PCT_W'($urandom_range(0, 100));
      c.mid_battery_pct = PCT_W'($urandom_range(0, 100));
      set_config(c);
      run_random(200);
    end

    // largest thresholds: the press never requests a reset, its quick release
    // shows a colour and the blink never toggles
    set_config({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd50, 7'd50});
    slow_ok = 1'b0;
    tx_calm = 1'b0;
    for (int k = 0; k < MAX_HOLD_TICKS + 10; k++) begin
      t.button_down   = (k < MAX_HOLD_TICKS);
      t.battery_pct   = PCT_W'($urandom_range(0, 100));
      t.portal_active = (k < MAX_HOLD_TICKS / 2);
      t.link_up       = (k < MAX_HOLD_TICKS / 2) ? 1'($urandom_range(0, 1)) : 1'b0;
      t.radio_off     = 1'b0;
      send_tick(t, 1'b0, PX_IDLE);
    end
    slow_ok = 1'b1;

    drain_results();
    $display("summary: %0d tick transfers, %0d pixel transfers checked, %0d register writes",
             ticks_sent, results_seen, reg_writes);
    $display("summary: %0d reset requests and %0d battery colour displays predicted",
             request_count, show_count);
    if (fail_count == 0 && pixel_expect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("mismatches: %0d, pixels still predicted: %0d", fail_count, pixel_expect.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
